// ===== rtl/core/acx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acx_pkg: shared types, tables and round functions
// S-box, round constants and the AES round for the counter-mode core.
// ----------------------------------------------------------------------------
package acx_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYGEN,
		ST_CTR,
		ST_INIT,
		ST_ROUND,
		ST_DONE
	} seq_state_t;

	typedef enum logic [2:0] {
		REG_KEY0,
		REG_KEY1,
		REG_KEY2,
		REG_KEY3,
		REG_KEY_SIZE,
		REG_IV_HIGH,
		REG_IV_LOW,
		REG_START_BLOCK
	} reg_index_t;

	typedef enum logic [1:0] {
		KEY_128 = 2'd0,
		KEY_192 = 2'd1,
		KEY_256 = 2'd2,
		KEY_256_ALIAS = 2'd3
	} key_size_t;

	// One schedule word written into the round key store.
	typedef struct packed {
		logic        we;
		logic [3:0]  row;
		logic [1:0]  lane;
		logic [31:0] word;
	} ks_wr_t;

	// Controls for the shared round unit.
	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} rnd_ctl_t;

	localparam int RK_ROWS    = 15;
	localparam int BLK_BYTES  = 16;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [16] = '{
		8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
		8'h80,8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// SubBytes and ShiftRows, then MixColumns unless this is the final round.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] res;
		for (int k = 0; k < 16; k++) begin
			b[k] = s[127 - 8 * k -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[r + 4 * c] = SBOX[b[r + 4 * ((c + r) & 3)]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				x  = a0 ^ a1 ^ a2 ^ a3;
				t[4 * c]     = a0 ^ x ^ xtime(a0 ^ a1);
				t[4 * c + 1] = a1 ^ x ^ xtime(a1 ^ a2);
				t[4 * c + 2] = a2 ^ x ^ xtime(a2 ^ a3);
				t[4 * c + 3] = a3 ^ x ^ xtime(a3 ^ a0);
			end
		end
		for (int k = 0; k < 16; k++) begin
			res[127 - 8 * k -: 8] = t[k];
		end
		aes_round = res;
	endfunction

endpackage

// ===== rtl/core/acx_key_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acx_key_sched: iterative key expansion
// Produces one 32-bit schedule word per cycle for the round key store.
// ----------------------------------------------------------------------------
module acx_key_sched (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [255:0]          key,
	input  logic [1:0]            key_size,
	output logic                  busy,
	output logic                  done,
	output acx_pkg::ks_wr_t       wr
);

	logic        busy_q;
	logic [5:0]  i_q;
	logic [5:0]  last_q;
	logic [2:0]  m_q;
	logic [3:0]  d_q;
	logic [3:0]  nk_q;
	logic [31:0] sr_q [8];
	logic [7:0][31:0] kw;
	logic [31:0] t;
	logic [31:0] word;
	logic [2:0]  nk_m1;

	assign kw    = key;
	assign nk_m1 = 3'(nk_q - 4'd1);

	always_comb begin
		t = sr_q[0];
		if (m_q == 3'd0) begin
			t = acx_pkg::sub_word({sr_q[0][23:0], sr_q[0][31:24]})
				^ {acx_pkg::RCON[d_q], 24'h0};
		end else if (nk_q == 4'd8 && m_q == 3'd4) begin
			t = acx_pkg::sub_word(sr_q[0]);
		end
		if (i_q < 6'(nk_q)) begin
			word = kw[3'd7 - i_q[2:0]];
		end else begin
			word = sr_q[nk_m1] ^ t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			m_q    <= '0;
			d_q    <= '0;
			nk_q   <= 4'd4;
			last_q <= 6'd43;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
			m_q    <= '0;
			d_q    <= '0;
			case (key_size)
				acx_pkg::KEY_128: begin
					nk_q   <= 4'd4;
					last_q <= 6'd43;
				end
				acx_pkg::KEY_192: begin
					nk_q   <= 4'd6;
					last_q <= 6'd51;
				end
				default: begin
					nk_q   <= 4'd8;
					last_q <= 6'd59;
				end
			endcase
		end else if (busy_q) begin
			i_q <= i_q + 6'd1;
			if (m_q == nk_m1) begin
				m_q <= '0;
				d_q <= d_q + 4'd1;
			end else begin
				m_q <= m_q + 3'd1;
			end
			if (i_q == last_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			sr_q[0] <= word;
			for (int j = 1; j < 8; j++) begin
				sr_q[j] <= sr_q[j - 1];
			end
		end
	end

	assign busy    = busy_q;
	assign done    = busy_q && (i_q == last_q);
	assign wr.we   = busy_q;
	assign wr.row  = i_q[5:2];
	assign wr.lane = i_q[1:0];
	assign wr.word = word;

endmodule

// ===== rtl/core/acx_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acx_round: shared AES round unit
// Holds the cipher state and applies one round per step.
// ----------------------------------------------------------------------------
module acx_round (
	input  logic                 clk,
	input  acx_pkg::rnd_ctl_t    ctl,
	input  logic [127:0]         init,
	input  logic [127:0]         rk,
	output logic [127:0]         state
);

	logic [127:0] st_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			st_q <= init ^ rk;
		end else if (ctl.step) begin
			st_q <= acx_pkg::aes_round(st_q, ctl.last) ^ rk;
		end
	end

	assign state = st_q;

endmodule

// ===== rtl/core/aes_ctr_keystream_xor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ctr_keystream_xor_core: AES-128/192/256 counter mode, one block per word
// Encrypts the running counter and XORs the keystream into the data word.
// ----------------------------------------------------------------------------
// Usage. Key, key size, IV and start block are written through the cfg port;
// the user must write them only while the core is idle, which the core does
// not enforce. Each input word carries 16 data bytes, a valid byte count and
// a first-block flag; each produces exactly one output word. A word with
// first_block set restarts the block index and first expands the key, one
// schedule word per cycle: 44, 52 or 60 words for 128, 192 or 256 bit keys.
// The cipher then runs one round per cycle on a single shared round unit,
// reading the stored round keys in sequence from a 15-row memory. The
// sequencer steps through KEYGEN (first block only), CTR, INIT, ROUND and
// DONE, then loads the output register; a new word is accepted only back in
// idle. in_stall is high while a word is being worked on. The output register
// holds the result until the receiver takes it; a new input word may be
// accepted while it waits, and the core only holds in its final step if the
// previous result is still pending. Reset clears the sequencer, block index,
// round counters, config registers and output valid flag; the round key memory
// has no reset and must be built by a first-block word.
// ----------------------------------------------------------------------------
module aes_ctr_keystream_xor_core (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	// Input channel.
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [63:0]  data_high,
	input  logic [63:0]  data_low,
	input  logic [4:0]   valid_bytes,
	input  logic         first_block,
	// Output channel.
	output logic         out_valid,
	input  logic         out_stall,
	output logic [63:0]  result_high,
	output logic [63:0]  result_low,
	output logic [4:0]   result_bytes
);

	// Configuration registers.
	logic [63:0] key0_q, key1_q, key2_q, key3_q;
	logic [1:0]  key_size_q;
	logic [63:0] iv_high_q, iv_low_q, start_block_q;

	acx_pkg::seq_state_t state_q, state_d;

	logic [63:0]  block_index_q;
	logic [63:0]  add_q;
	logic [127:0] data_q;
	logic [4:0]   nbytes_q;
	logic [3:0]   nr_q;
	logic [3:0]   rnd_q;
	logic         out_valid_q;
	logic [63:0]  res_high_q, res_low_q;
	logic [4:0]   res_bytes_q;

	logic         in_acc;
	logic         out_acc;
	logic         ks_start;
	logic         ks_busy;
	logic         ks_done;
	acx_pkg::ks_wr_t  ks_wr;
	acx_pkg::rnd_ctl_t rctl;
	logic [127:0] ctr_init;
	logic [127:0] cipher;
	logic [127:0] masked;
	logic [63:0]  ctr_lo;
	logic         ctr_carry;

	// Round key memory: one 128-bit row per round, written a word at a time.
	logic [3:0][31:0] rk_mem [acx_pkg::RK_ROWS];
	logic [127:0]     rk_q;
	logic [3:0]       rd_addr;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign in_stall = (state_q != acx_pkg::ST_IDLE);
	assign ks_start = in_acc && first_block;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q        <= '0;
			key1_q        <= '0;
			key2_q        <= '0;
			key3_q        <= '0;
			key_size_q    <= '0;
			iv_high_q     <= '0;
			iv_low_q      <= '0;
			start_block_q <= '0;
		end else if (cfg_we) begin
			unique case (acx_pkg::reg_index_t'(cfg_index))
				acx_pkg::REG_KEY0:        key0_q        <= cfg_data;
				acx_pkg::REG_KEY1:        key1_q        <= cfg_data;
				acx_pkg::REG_KEY2:        key2_q        <= cfg_data;
				acx_pkg::REG_KEY3:        key3_q        <= cfg_data;
				acx_pkg::REG_KEY_SIZE:    key_size_q    <= cfg_data[1:0];
				acx_pkg::REG_IV_HIGH:     iv_high_q     <= cfg_data;
				acx_pkg::REG_IV_LOW:      iv_low_q      <= cfg_data;
				acx_pkg::REG_START_BLOCK: start_block_q <= cfg_data;
				default: ;
			endcase
		end
	end

	acx_key_sched u_key_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ks_start),
		.key      ({key0_q, key1_q, key2_q, key3_q}),
		.key_size (key_size_q),
		.busy     (ks_busy),
		.done     (ks_done),
		.wr       (ks_wr)
	);

	always_ff @(posedge clk) begin
		if (ks_wr.we) begin
			rk_mem[ks_wr.row][2'd3 - ks_wr.lane] <= ks_wr.word;
		end
		if (rd_addr < 4'(acx_pkg::RK_ROWS)) begin
			rk_q <= rk_mem[rd_addr];
		end
	end

	// The counter is IV plus (start block + index); the low-word carry goes
	// into the high word.
	assign ctr_lo    = iv_low_q + add_q;
	assign ctr_carry = (ctr_lo < iv_low_q);
	assign ctr_init  = {iv_high_q + {63'd0, ctr_carry}, ctr_lo};

	acx_round u_round (
		.clk   (clk),
		.ctl   (rctl),
		.init  (ctr_init),
		.rk    (rk_q),
		.state (cipher)
	);

	// Keystream XOR with the bytes past the valid count forced to zero.
	always_comb begin
		for (int k = 0; k < acx_pkg::BLK_BYTES; k++) begin
			masked[127 - 8 * k -: 8] = (5'(k) < nbytes_q)
				? (data_q[127 - 8 * k -: 8] ^ cipher[127 - 8 * k -: 8]) : 8'h00;
		end
	end

	// Sequencer: next state and controls.
	always_comb begin
		state_d   = state_q;
		rctl.load = 1'b0;
		rctl.step = 1'b0;
		rctl.last = (rnd_q == nr_q);
		rd_addr   = 4'd0;
		unique case (state_q)
			acx_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = first_block ? acx_pkg::ST_KEYGEN : acx_pkg::ST_CTR;
				end
			end
			acx_pkg::ST_KEYGEN: begin
				if (ks_done) begin
					state_d = acx_pkg::ST_CTR;
				end
			end
			acx_pkg::ST_CTR: begin
				state_d = acx_pkg::ST_INIT;
			end
			acx_pkg::ST_INIT: begin
				rctl.load = 1'b1;
				rd_addr   = 4'd1;
				state_d   = acx_pkg::ST_ROUND;
			end
			acx_pkg::ST_ROUND: begin
				rctl.step = 1'b1;
				rd_addr   = rnd_q + 4'd1;
				if (rnd_q == nr_q) begin
					state_d = acx_pkg::ST_DONE;
				end
			end
			acx_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = acx_pkg::ST_IDLE;
				end
			end
			default: state_d = acx_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= acx_pkg::ST_IDLE;
			block_index_q <= '0;
			nr_q          <= 4'd10;
			rnd_q         <= 4'd1;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ks_start) begin
				block_index_q <= '0;
				unique case (acx_pkg::key_size_t'(key_size_q))
					acx_pkg::KEY_128: nr_q <= 4'd10;
					acx_pkg::KEY_192: nr_q <= 4'd12;
					acx_pkg::KEY_256, acx_pkg::KEY_256_ALIAS: nr_q <= 4'd14;
					default: nr_q <= 4'd14;
				endcase
			end
			if (state_q == acx_pkg::ST_INIT) begin
				rnd_q <= 4'd1;
			end else if (state_q == acx_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 4'd1;
			end
			if (state_q == acx_pkg::ST_DONE && state_d == acx_pkg::ST_IDLE) begin
				out_valid_q   <= 1'b1;
				block_index_q <= block_index_q + 64'd1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q   <= {data_high, data_low};
			nbytes_q <= (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
		end
		if (state_q == acx_pkg::ST_CTR) begin
			add_q <= start_block_q + block_index_q;
		end
		if (state_q == acx_pkg::ST_DONE && state_d == acx_pkg::ST_IDLE) begin
			res_high_q  <= masked[127:64];
			res_low_q   <= masked[63:0];
			res_bytes_q <= nbytes_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_high  = res_high_q;
	assign result_low   = res_low_q;
	assign result_bytes = res_bytes_q;

	// A new result is only loaded from the final sequencer step.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == acx_pkg::ST_DONE))
		else $error("output loaded outside the final step");

	// The round unit never runs while the key schedule is still being written.
	a_no_round_during_keygen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == acx_pkg::ST_ROUND) |-> !ks_busy)
		else $error("round issued during key expansion");

	// The round counter stays within the latched round count.
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == acx_pkg::ST_ROUND) |-> (rnd_q <= nr_q && rnd_q != 4'd0))
		else $error("round counter out of range");

endmodule
